// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the contrast stretch block.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// pre in a cycle implies post in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// pre in a cycle implies post in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== src/mmcs_pkg.sv =====
// Package of the min-max contrast stretch block: field widths, codes, FSM type.
// No dependencies.
package mmcs_pkg;

   localparam int SAMPLE_IN_BITS = 16;
   localparam int PIX_BITS       = 8;
   localparam int DIV_STEPS      = 8;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCALE,
      ST_DIV,
      ST_HOLD
   } mmcs_state_type;

endpackage

// ===== src/mmcs_if.sv =====
// Valid/ready channel interfaces of the contrast stretch block.
// Depends on mmcs_pkg for the payload widths.
interface mmcs_req_if import mmcs_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic signed [SAMPLE_IN_BITS-1:0] sample;
   logic                             frame_end;

   modport source (output valid, output func, output sample, output frame_end,
                   input ready);
   modport sink   (input valid, input func, input sample, input frame_end,
                   output ready);
endinterface

interface mmcs_rsp_if import mmcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel;
   logic                final_res;

   modport source (output valid, output pixel, output final_res, input ready);
   modport sink   (input valid, input pixel, input final_res, output ready);
endinterface

// ===== src/minmax_contrast_stretch.sv =====
// Top level of the min-max contrast stretch: frame store, min/max tracking,
// radix-2 divider and result register. Depends on mmcs_pkg, mmcs_if.sv and
// assert_macros.svh.
//
//   channel   dir  payload                       transaction
//   req_ch    in   func, sample[15:0], frame_end valid && ready
//   rsp_ch    out  pixel[7:0], final_res         valid && ready
//
// Loads stream at one per cycle while no drain occupies the block.
// A drain transaction occupies the block for memory read, offset and
// span, scaling by 255, eight radix-2 divide steps, and the handoff to the
// result register. The eight-step divider and the single read port set its length.
// The result register frees the input side: a stalled result only blocks the
// next drain at its handoff cycle. Synchronous reset clears the control state;
// the frame store has no clearing pass, only entries of the current frame are
// read.
`include "assert_macros.svh"

module minmax_contrast_stretch import mmcs_pkg::*; #(
   parameter int MAX_PIXELS  = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mmcs_req_if.sink   req_ch,
   mmcs_rsp_if.source rsp_ch
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int S  = SAMPLE_BITS;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);
   localparam logic signed [32:0] SAT_TOP =
      33'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] SAT_BOT = -SAT_TOP - 33'sd1;
   localparam logic [2:0] LAST_STEP = 3'(DIV_STEPS - 1);

   // frame store, one write and one read port
   logic [S-1:0]  store [MAX_PIXELS];
   logic [S-1:0]  rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] wr_addr, rd_addr;

   // control state
   mmcs_state_type       state_ff, state_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                 frame_ready_ff, frame_ready_in;
   logic signed [S-1:0]  low_ff, low_in;
   logic signed [S-1:0]  high_ff, high_in;
   logic [2:0]           step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [S-1:0]          offset_ff, offset_in;
   logic [S-1:0]          span_ff, span_in;
   logic                  flat_ff, flat_in;
   logic                  last_ff, last_in;
   logic [S-1:0]          rem_ff, rem_in;
   logic [PIX_BITS-1:0]   quo_ff, quo_in;
   logic [PIX_BITS-1:0]   pixel_ff, pixel_in;
   logic                  final_ff, final_in;

   // combinational helpers
   logic signed [32:0]   samp_wide, samp_sat;
   logic signed [S-1:0]  samp_val;
   logic [CW-1:0]        fill_base;
   logic                 req_take;
   logic                 out_free;
   logic signed [S:0]    off_full, span_full;
   logic [S+7:0]         scaled;
   logic [S:0]           trial;
   logic [S+1:0]         trial_diff;
   logic                 trial_ge;

   // sign-extend, then saturate to the stored sample range
   always_comb begin
      samp_wide = 33'(req_ch.sample);
      if (samp_wide > SAT_TOP) begin
         samp_sat = SAT_TOP;
      end else if (samp_wide < SAT_BOT) begin
         samp_sat = SAT_BOT;
      end else begin
         samp_sat = samp_wide;
      end
      samp_val = samp_sat[S-1:0];
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign req_take         = req_ch.valid && req_ch.ready;
   assign out_free         = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pixel     = pixel_ff;
   assign rsp_ch.final_res = final_ff;

   // a load on a closed frame restarts the store at entry zero
   assign fill_base = frame_ready_ff ? '0 : fill_ff;
   assign wr_addr   = fill_base[AW-1:0];
   assign rd_addr   = rd_ptr_ff[AW-1:0];

   // distances from the minimum; both are never negative
   assign off_full  = (S+1)'(signed'(rd_data_ff)) - (S+1)'(low_ff);
   assign span_full = (S+1)'(high_ff) - (S+1)'(low_ff);
   // 255 * offset as a shift and subtract
   assign scaled    = {offset_ff, 8'b0} - {8'b0, offset_ff};

   // one restoring divide step
   assign trial      = {rem_ff, quo_ff[PIX_BITS-1]};
   assign trial_diff = {1'b0, trial} - {2'b0, span_ff};
   assign trial_ge   = !trial_diff[S+1];

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      rd_ptr_in      = rd_ptr_ff;
      frame_ready_in = frame_ready_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      offset_in      = offset_ff;
      span_in        = span_ff;
      flat_in        = flat_ff;
      last_in        = last_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      pixel_in       = pixel_ff;
      final_in       = final_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_ch.func == FUNC_LOAD) begin
               if (frame_ready_ff) begin
                  rd_ptr_in = '0;
               end
               fill_in = fill_base;
               if (fill_base < MAX_CNT) begin
                  mem_we  = 1'b1;
                  fill_in = fill_base + 1'b1;
                  if (fill_base == '0 || samp_val < low_ff) begin
                     low_in = samp_val;
                  end
                  if (fill_base == '0 || samp_val > high_ff) begin
                     high_in = samp_val;
                  end
               end
               frame_ready_in = req_ch.frame_end;
            end else if (req_take && req_ch.func == FUNC_DRAIN) begin
               // drain before close or past the end gives no result
               if (frame_ready_ff && rd_ptr_ff != fill_ff) begin
                  mem_re    = 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
                  last_in   = (rd_ptr_ff + 1'b1 == fill_ff);
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            offset_in = off_full[S-1:0];
            span_in   = span_full[S-1:0];
            flat_in   = (high_ff == low_ff);
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            // quotient fits 8 bits, so the top part is already below span
            rem_in   = scaled[S+7:8];
            quo_in   = scaled[7:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[S-1:0] : trial[S-1:0];
            quo_in  = {quo_ff[PIX_BITS-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pixel_in     = flat_ff ? '0 : quo_ff;
               final_in     = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_ff        <= '0;
         rd_ptr_ff      <= '0;
         frame_ready_ff <= 1'b0;
         low_ff         <= '0;
         high_ff        <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         rd_ptr_ff      <= rd_ptr_in;
         frame_ready_ff <= frame_ready_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      span_ff   <= span_in;
      flat_ff   <= flat_in;
      last_ff   <= last_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      pixel_ff  <= pixel_in;
      final_ff  <= final_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_addr] <= samp_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   `ASSERT_ALWAYS(a_ptr_in_frame, clock, reset, rd_ptr_ff <= fill_ff && fill_ff <= MAX_CNT)
   `ASSERT_IMPLY(a_read_closed, clock, reset, state_ff == ST_READ, $past(frame_ready_ff))
   `ASSERT_NEXT(a_div_exit, clock, reset, state_ff == ST_DIV, state_ff == ST_DIV || state_ff == ST_HOLD)
   `ASSERT_IMPLY(a_step_div, clock, reset, step_ff != '0, state_ff == ST_DIV)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for minmax_contrast_stretch: random and directed load/drain traffic.
// Needs mmcs_pkg, the mmcs_req_if/mmcs_rsp_if interfaces and the block itself.
`timescale 1ns / 1ps

module testbench;
   import mmcs_pkg::*;

   localparam int          STORE_DEPTH   = 65536;
   localparam int          PHASE_ITEMS   = 200;
   localparam int          TAIL_CYCLES   = 40;       // leave margin for a drain still in flight
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic                last_pixel;
   } stretched_pixel_type;

   // Tracks the frame exactly as the block should and queues the pixels it owes.
   class contrast_predictor_type;
      logic signed [SAMPLE_IN_BITS-1:0] samples [STORE_DEPTH];
      logic signed [SAMPLE_IN_BITS-1:0] frame_min;
      logic signed [SAMPLE_IN_BITS-1:0] frame_max;
      int unsigned                      stored_count;
      int unsigned                      drained_count;
      bit                               frame_closed;
      stretched_pixel_type              expected_pixels [$];
      int unsigned                      errors;

      function new();
         frame_min     = '0;
         frame_max     = '0;
         stored_count  = 0;
         drained_count = 0;
         frame_closed  = 1'b0;
         errors        = 0;
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void note_request(logic func, logic signed [SAMPLE_IN_BITS-1:0] sample,
                                 logic frame_end);
         logic [16:0]         span;
         logic [16:0]         offset;
         logic [24:0]         quotient;
         stretched_pixel_type want;
         if (func == FUNC_LOAD) begin
            // loading into a closed frame starts a fresh one
            if (frame_closed) begin
               stored_count  = 0;
               drained_count = 0;
               frame_closed  = 1'b0;
            end
            // a full store drops the sample, min/max untouched
            if (stored_count < STORE_DEPTH) begin
               samples[stored_count] = sample;
               if (stored_count == 0) begin
                  frame_min = sample;
                  frame_max = sample;
               end else begin
                  if (sample < frame_min) frame_min = sample;
                  if (sample > frame_max) frame_max = sample;
               end
               stored_count++;
            end
            if (frame_end) frame_closed = 1'b1;
         end else if (frame_closed && drained_count < stored_count) begin
            span   = 17'(int'(frame_max) - int'(frame_min));
            offset = 17'(int'(samples[drained_count]) - int'(frame_min));
            // flat frame gives zero
            quotient = (span == 0) ? 25'd0 : (25'(offset) * 25'd255) / 25'(span);
            if (quotient > 25'd255) quotient = 25'd255;
            drained_count++;
            want.pixel      = quotient[PIX_BITS-1:0];
            want.last_pixel = (drained_count == stored_count);
            expected_pixels.push_back(want);
         end
         // drains on an open or exhausted frame owe nothing
      endfunction

      function void check_pixel(logic [PIX_BITS-1:0] pixel, logic last_pixel);
         stretched_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none actual pixel %0d final_res %0b",
                     $time, pixel, last_pixel);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         if (pixel !== want.pixel) begin
            $display("%0t: pixel mismatch, expected %0d actual %0d",
                     $time, want.pixel, pixel);
            errors++;
         end
         if (last_pixel !== want.last_pixel) begin
            $display("%0t: final_res mismatch, expected %0b actual %0b",
                     $time, want.last_pixel, last_pixel);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mmcs_req_if req_ch ();
   mmcs_rsp_if rsp_ch ();

   minmax_contrast_stretch #(
      .MAX_PIXELS  (STORE_DEPTH),
      .SAMPLE_BITS (16)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   contrast_predictor_type predict;

   int          src_idle_pct;    // chance per cycle that the sender holds off
   int          sink_idle_pct;   // chance per cycle that the receiver stalls
   int unsigned sent_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: ready is redrawn at every falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Monitor: every transaction is picked up at the rising edge where it happens.
   // Inputs are only ever changed at the falling edge, so there is no race here.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            predict.note_request(req_ch.func, req_ch.sample, req_ch.frame_end);
         if (rsp_ch.valid && rsp_ch.ready)
            predict.check_pixel(rsp_ch.pixel, rsp_ch.final_res);
      end
   end

   // Watchdog: a hang or a lost pixel ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Called right after a falling edge; returns right after the falling edge that
   // follows acceptance, so valid stays high across back-to-back transactions.
   task automatic send_request(input logic func, input logic signed [15:0] sample,
                               input logic frame_end);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.sample    <= sample;
      req_ch.frame_end <= frame_end;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic load_sample(input logic signed [15:0] sample, input logic frame_end);
      send_request(FUNC_LOAD, sample, frame_end);
   endtask

   // sample and frame_end are don't-care on a drain; random to toggle the bits
   task automatic drain_pixel();
      send_request(FUNC_DRAIN, 16'($urandom), 1'($urandom));
   endtask

   // One frame with random content, then a drain pattern: mostly complete,
   // sometimes overrun, sometimes abandoned part way.
   task automatic random_frame();
      int unsigned                 n;
      int unsigned                 kind;
      int unsigned                 drains;
      int unsigned                 pick;
      logic signed [15:0]          base;
      logic signed [15:0]          value;
      n      = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      kind   = $urandom_range(3);
      base   = 16'($urandom);
      for (int unsigned k = 0; k < n; k++) begin
         case (kind)
            0: value = 16'($urandom);                      // full range
            1: value = base + 16'($urandom_range(40));     // narrow span
            2: value = base;                               // flat frame
            default: begin                                 // extremes mixed in
               pick  = $urandom_range(2);
               value = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7fff : base;
            end
         endcase
         // occasional drain while the frame is still open
         if ($urandom_range(19) == 0) drain_pixel();
         load_sample(value, k == n - 1);
      end
      pick = $urandom_range(9);
      if (pick < 7)       drains = n;
      else if (pick == 7) drains = n + $urandom_range(2, 1);   // past the last pixel
      else                drains = $urandom_range(n - 1);      // abandoned frame
      repeat (drains) drain_pixel();
   endtask

   task automatic run_phase(input int src_pct, input int sink_pct);
      int unsigned start;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      start         = sent_count;
      while (sent_count - start < PHASE_ITEMS) random_frame();
   endtask

   initial begin
      predict          = new();
      sent_count       = 0;
      src_idle_pct     = 10;
      sink_idle_pct    = 46;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.func      = FUNC_LOAD;
      req_ch.sample    = '0;
      req_ch.frame_end = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---
      drain_pixel();                       // nothing loaded yet
      load_sample(16'sh8000, 1'b1);        // single sample: flat, first sets min and max
      drain_pixel();
      drain_pixel();                       // past the end
      load_sample(16'sh7fff, 1'b0);        // new frame after a finished one
      load_sample(16'sh8000, 1'b0);
      drain_pixel();                       // frame still open
      load_sample(16'sh0000, 1'b0);
      load_sample(16'shffff, 1'b0);
      load_sample(16'sh0001, 1'b1);
      repeat (6) drain_pixel();            // five pixels, one too many
      load_sample(16'sd12345, 1'b0);       // flat frame of three
      load_sample(16'sd12345, 1'b0);
      load_sample(16'sd12345, 1'b1);
      repeat (2) drain_pixel();            // abandoned after two
      load_sample(16'sd100, 1'b0);
      load_sample(16'sd200, 1'b0);
      load_sample(16'sd150, 1'b1);
      repeat (3) drain_pixel();

      // --- random, three idling regimes ---
      run_phase(10, 46);
      run_phase(46, 10);
      run_phase(0, 0);

      req_ch.valid <= 1'b0;
      while (predict.pending() != 0) @(posedge clock);
      // a trailing drain may owe nothing; let the block settle before judging
      repeat (TAIL_CYCLES) @(posedge clock);

      if (predict.errors == 0 && predict.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
